FILE: rtl/core/assert_macros.svh
// assertion helpers shared by the rtl, sampled on clk_i and held off in reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every edge
`define HCT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// antecedent implies consequent in the same cycle
`define HCT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define HCT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/hct_pkg.sv
package hct_pkg;

  localparam int unsigned TableEntriesDefault = 64;

  localparam int unsigned HeightW   = 32;
  localparam int unsigned HashW     = 256;
  localparam int unsigned InDataW   = 320;
  localparam int unsigned OutDataW  = 8;

  typedef enum logic [1:0] {
    StatusOk   = 2'd0,
    StatusDup  = 2'd1,
    StatusFull = 2'd2
  } status_e;

  localparam logic OpInsert = 1'b0;
  localparam logic OpQuery  = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic capture;   // latch the input beat, restart the scan
    logic scan_rd;   // read the next stored height
    logic hash_rd;   // read the hash of the matching slot
    logic load_out;  // load the result register, commit an insert
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_issued;  // every stored height has been read
    logic rd_busy;      // a height read is still in flight
    logic query_hit;    // query whose height is stored
    logic out_free;     // result register can take a new beat
  } sts_t;

endpackage

FILE: rtl/core/hct_ctrl.sv
`include "assert_macros.svh"

module hct_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  hct_pkg::sts_t sts_i,
  output hct_pkg::cmd_t cmd_o
);
  import hct_pkg::*;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StHash,
    StResult
  } state_e;

  state_e state_q;
  state_e state_d;
  logic   scan_end;

  assign scan_end = sts_i.scan_issued && !sts_i.rd_busy;

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    in_ready_o     = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
        if (in_valid_i) begin
          state_d = StScan;
        end
      end
      StScan: begin
        cmd_o.scan_rd = !sts_i.scan_issued;
        if (scan_end) begin
          state_d = sts_i.query_hit ? StHash : StResult;
        end
      end
      StHash: begin
        cmd_o.hash_rd = 1'b1;
        state_d       = StResult;
      end
      StResult: begin
        cmd_o.load_out = sts_i.out_free;
        if (sts_i.out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  `HCT_ASSERT_IMP(load_needs_free, cmd_o.load_out, sts_i.out_free, "result loaded over a held beat")
  `HCT_ASSERT_IMP(no_hash_rd_on_miss, state_q == StScan && scan_end && !sts_i.query_hit, state_d == StResult, "hash read without a hit")

endmodule

FILE: rtl/core/hct_datapath.sv
`include "assert_macros.svh"

module hct_datapath #(
  parameter int unsigned TableEntries = hct_pkg::TableEntriesDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  hct_pkg::cmd_t                 cmd_i,
  output hct_pkg::sts_t                 sts_o,
  input  logic                          in_op_i,
  input  logic [hct_pkg::InDataW-1:0]   in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [hct_pkg::OutDataW-1:0]  out_data_o
);
  import hct_pkg::*;

  localparam int unsigned CntW  = $clog2(TableEntries + 1);
  localparam int unsigned AddrW = (TableEntries > 1) ? $clog2(TableEntries) : 1;

  // stored checkpoints, slots filled in insertion order
  logic [HeightW-1:0] height_mem [TableEntries];
  logic [HashW-1:0]   hash_mem   [TableEntries];

  // captured item
  logic               op_q;
  logic [HeightW-1:0] height_q;
  logic [HeightW-1:0] chain_q;
  logic [HashW-1:0]   hash_q;

  // scan and result state
  logic [CntW-1:0]    count_q;
  logic [CntW-1:0]    rd_idx_q;
  logic               rd_vld_q;
  logic [AddrW-1:0]   rd_slot_q;
  logic [HeightW-1:0] rd_height_q;
  logic [HashW-1:0]   rd_hash_q;
  logic               found_q;
  logic [AddrW-1:0]   slot_q;
  logic               any_q;
  logic [HeightW-1:0] max_q;
  logic               any_le_q;
  logic [HeightW-1:0] best_le_q;
  logic               out_vld_q;
  logic [OutDataW-1:0] out_data_q;

  logic               full;
  logic               do_write;
  status_e            status;
  logic               is_cp;
  logic               hash_ok;
  logic               in_zone;
  logic               alt_ok;

  assign full     = (count_q == CntW'(TableEntries));
  assign do_write = cmd_i.load_out && (op_q == OpInsert) && !found_q && !full;

  always_comb begin
    status  = StatusOk;
    is_cp   = 1'b0;
    hash_ok = 1'b0;
    in_zone = 1'b0;
    alt_ok  = 1'b0;
    if (op_q == OpInsert) begin
      if (found_q) begin
        status = StatusDup;
      end else if (full) begin
        status = StatusFull;
      end
    end else begin
      is_cp   = found_q;
      hash_ok = !found_q || (rd_hash_q == hash_q);
      in_zone = any_q && (height_q <= max_q);
      if (height_q == '0) begin
        alt_ok = 1'b0;
      end else if (!any_le_q) begin
        alt_ok = 1'b1;
      end else begin
        alt_ok = (best_le_q < height_q);
      end
    end
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (do_write) begin
      height_mem[count_q[AddrW-1:0]] <= height_q;
      hash_mem[count_q[AddrW-1:0]]   <= hash_q;
    end
    if (cmd_i.scan_rd) begin
      rd_height_q <= height_mem[rd_idx_q[AddrW-1:0]];
    end
    if (cmd_i.hash_rd) begin
      rd_hash_q <= hash_mem[slot_q];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q     <= in_op_i;
      height_q <= in_data_i[HeightW-1:0];
      chain_q  <= in_data_i[2*HeightW-1:HeightW];
      hash_q   <= in_data_i[InDataW-1:2*HeightW];
      found_q  <= 1'b0;
      any_q    <= 1'b0;
      any_le_q <= 1'b0;
    end else if (rd_vld_q) begin
      if (rd_height_q == height_q) begin
        found_q <= 1'b1;
        slot_q  <= rd_slot_q;
      end
      if (!any_q || rd_height_q > max_q) begin
        max_q <= rd_height_q;
      end
      any_q <= 1'b1;
      if (rd_height_q <= chain_q && (!any_le_q || rd_height_q > best_le_q)) begin
        best_le_q <= rd_height_q;
        any_le_q  <= 1'b1;
      end
    end
    if (cmd_i.scan_rd) begin
      rd_slot_q <= rd_idx_q[AddrW-1:0];
    end
    if (cmd_i.load_out) begin
      out_data_q <= {2'b00, alt_ok, in_zone, hash_ok, is_cp, status};
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      rd_idx_q  <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (do_write) begin
        count_q <= count_q + CntW'(1);
      end
      if (cmd_i.capture) begin
        rd_idx_q <= '0;
      end else if (cmd_i.scan_rd) begin
        rd_idx_q <= rd_idx_q + CntW'(1);
      end
      rd_vld_q <= cmd_i.scan_rd;
      if (cmd_i.load_out) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign sts_o.scan_issued = (rd_idx_q == count_q);
  assign sts_o.rd_busy     = rd_vld_q;
  assign sts_o.query_hit   = (op_q == OpQuery) && found_q;
  assign sts_o.out_free    = !out_vld_q || out_ready_i;

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_data_q;

  `HCT_ASSERT(count_in_range, count_q <= CntW'(TableEntries), "entry count past table size")
  `HCT_ASSERT(scan_in_range, rd_idx_q <= count_q, "scan read past last stored entry")
  `HCT_ASSERT_NXT(count_only_on_load, !cmd_i.load_out, $stable(count_q), "entry count moved without a result")

endmodule

FILE: rtl/core/height_checkpoint_table.sv
// checkpoint table: holds up to TableEntries checkpoints, each a 32-bit block
// height with its 256-bit hash, and answers one result beat for each input
// beat. tuser selects the operation: an insert adds the height and hash unless
// the height is already stored (status duplicate) or the table is full (status
// full); a query reports whether the height is a checkpoint, whether its hash
// matches the stored one, whether it lies at or below the highest checkpoint,
// and whether an alternative block at that height is allowed for the given
// chain height. the table is empty after reset. each beat scans the stored
// heights through the single read port of the height memory, one entry per
// cycle, and the input is ready again in the cycle after its result is
// loaded into the output register. a new beat is accepted while the
// previous result still waits on the output side.
module height_checkpoint_table #(
  parameter int unsigned TableEntries = hct_pkg::TableEntriesDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input beat
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // height [31:0], chain_height [63:32], hash_w0 [127:64], hash_w1 [191:128],
  // hash_w2 [255:192], hash_w3 [319:256]
  input  logic [hct_pkg::InDataW-1:0]   s_axis_tdata_i,
  // op: 0 insert, 1 query
  input  logic                          s_axis_tuser_i,
  // result beat
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // status [1:0], is_checkpoint [2], hash_ok [3], in_zone [4], alt_allowed [5],
  // zero [7:6]
  output logic [hct_pkg::OutDataW-1:0]  m_axis_tdata_o
);
  import hct_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencing of capture, scan, hash read and result load
  hct_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // table memories, scan accumulators and the result register
  hct_datapath #(
    .TableEntries (TableEntries)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_op_i     (s_axis_tuser_i),
    .in_data_i   (s_axis_tdata_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o)
  );

endmodule

FILE: verif/hct_scoreboard_pkg.sv
`timescale 1ns / 1ps

package hct_scoreboard_pkg;

  import hct_pkg::*;

  // one result beat as the table should answer it
  typedef struct packed {
    status_e status;
    logic    is_checkpoint;
    logic    hash_ok;
    logic    in_zone;
    logic    alt_ok;
  } verdict_t;

  class checkpoint_scoreboard;

    // shadow copy of the stored checkpoints, slot order = insertion order
    logic [31:0]  cp_height[$];
    logic [255:0] cp_hash[$];
    verdict_t     pending_verdicts[$];
    int           errors;

    function new();
      errors = 0;
    endfunction

    function int slot_of(logic [31:0] height);
      int slot;
      slot = -1;
      foreach (cp_height[i]) begin
        if (cp_height[i] == height) slot = i;
      end
      return slot;
    endfunction

    function logic [31:0] highest_height();
      logic [31:0] top;
      top = '0;
      foreach (cp_height[i]) begin
        if (cp_height[i] > top) top = cp_height[i];
      end
      return top;
    endfunction

    // new checkpoint goes into the next free slot
    function void store_checkpoint(logic [31:0] height, logic [255:0] hash);
      cp_height.insert(cp_height.size(), height);
      cp_hash.insert(cp_hash.size(), hash);
    endfunction

    // expected answers wait in acceptance order
    function void queue_verdict(verdict_t v);
      pending_verdicts.insert(pending_verdicts.size(), v);
    endfunction

    // answer of the table to one accepted beat, updates the shadow table
    function verdict_t predict_verdict(logic op, logic [31:0] height, logic [31:0] chain,
                                       logic [255:0] hash);
      verdict_t    v;
      int          slot;
      logic        any_le;
      logic [31:0] best_le;
      v = '0;
      v.status = StatusOk;
      slot = slot_of(height);
      any_le = 1'b0;
      best_le = '0;
      if (op == OpInsert) begin
        if (slot >= 0) begin
          v.status = StatusDup;
        end else if (cp_height.size() >= TableEntriesDefault) begin
          v.status = StatusFull;
        end else begin
          store_checkpoint(height, hash);
        end
      end else begin
        v.is_checkpoint = (slot >= 0);
        v.hash_ok = (slot < 0) || (cp_hash[slot] == hash);
        v.in_zone = (cp_height.size() > 0) && (height <= highest_height());
        foreach (cp_height[i]) begin
          if (cp_height[i] <= chain && (!any_le || cp_height[i] > best_le)) begin
            best_le = cp_height[i];
            any_le = 1'b1;
          end
        end
        v.alt_ok = (height != 0) && (!any_le || best_le < height);
      end
      return v;
    endfunction

    function void note_input(logic op, logic [31:0] height, logic [31:0] chain,
                             logic [255:0] hash);
      queue_verdict(predict_verdict(op, height, chain, hash));
    endfunction

    function void compare_field(string name, logic [1:0] want, logic [1:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [7:0] beat);
      verdict_t want;
      if (pending_verdicts.size() == 0) begin
        $display("%0t: result beat 0x%02h with nothing pending, expected none, actual one",
                 $time, beat);
        errors++;
        return;
      end
      want = pending_verdicts.pop_front();
      compare_field("status", want.status, beat[1:0]);
      compare_field("is_checkpoint", {1'b0, want.is_checkpoint}, {1'b0, beat[2]});
      compare_field("hash_ok", {1'b0, want.hash_ok}, {1'b0, beat[3]});
      compare_field("in_zone", {1'b0, want.in_zone}, {1'b0, beat[4]});
      compare_field("alt_allowed", {1'b0, want.alt_ok}, {1'b0, beat[5]});
      compare_field("pad", 2'b00, beat[7:6]);
    endfunction

  endclass

endpackage

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  import hct_pkg::*;
  import hct_scoreboard_pkg::*;

  // a beat scans every stored entry before its result is loaded
  localparam int unsigned SettleCycles  = 200;
  // no beat moves on either side for this long means the block is stuck; covers
  // the long receiver hold-off plus a full scan with margin
  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned HoldCycles    = 300;
  localparam int unsigned RandomBeats   = 1835;

  logic                 clk_i;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  // height [31:0], chain_height [63:32], hash_w0..hash_w3 [319:64]
  logic [InDataW-1:0]   s_axis_tdata = '0;
  // op: 0 insert, 1 query
  logic                 s_axis_tuser = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  // status [1:0], is_checkpoint [2], hash_ok [3], in_zone [4], alt_allowed [5]
  logic [OutDataW-1:0]  m_axis_tdata;

  checkpoint_scoreboard sb;

  // calm: neither side idles; hold_request: ask the receiver for a long hold-off
  bit          calm = 1'b0;
  bit          hold_request = 1'b0;
  int unsigned idle_span = 0;

  height_checkpoint_table uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [255:0] rand_hash();
    return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
  endfunction

  // heights cluster low, spread over the whole range, or crowd the top
  function automatic logic [31:0] pick_height();
    case ($urandom_range(0, 3))
      0, 1:    return $urandom_range(0, 4095);
      2:       return $urandom;
      default: return 32'hFFFF_F000 + $urandom_range(0, 4095);
    endcase
  endfunction

  // offer one beat and hold it until accepted, then hand it to the scoreboard
  task automatic drive_beat(logic op, logic [31:0] height, logic [31:0] chain,
                            logic [255:0] hash);
    while (!calm && $urandom_range(0, 99) < 11) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {hash, chain, height};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_input(op, height, chain, hash);
  endtask

  // random query: heights near stored ones, chain heights straddling them
  task automatic drive_query();
    logic [31:0]  height;
    logic [31:0]  chain;
    logic [31:0]  near;
    logic [255:0] hash;
    int           filled;
    int           slot;
    filled = sb.cp_height.size();
    near = (filled > 0) ? sb.cp_height[$urandom_range(0, filled - 1)] : pick_height();
    case ($urandom_range(0, 7))
      0, 1, 2: height = near;
      3:       height = near + 1;
      4:       height = near - 1;
      5:       height = sb.highest_height() + $urandom_range(0, 1);
      6:       height = pick_height();
      default: height = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
    endcase
    near = (filled > 0) ? sb.cp_height[$urandom_range(0, filled - 1)] : pick_height();
    case ($urandom_range(0, 7))
      0, 1:    chain = near;
      2:       chain = near + 1;
      3:       chain = near - 1;
      4:       chain = height;
      5:       chain = height - 1;
      6:       chain = $urandom;
      default: chain = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
    endcase
    slot = sb.slot_of(height);
    hash = rand_hash();
    if (slot >= 0) begin
      case ($urandom_range(0, 4))
        0, 1, 2: hash = sb.cp_hash[slot];
        3:       hash = sb.cp_hash[slot] ^ (256'd1 << $urandom_range(0, 255));
        default: ;
      endcase
    end
    drive_beat(OpQuery, height, chain, hash);
  endtask

  // result side: random back-pressure, plus one long hold-off on request
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (rst_ni) begin
        m_axis_tready <= calm || ($urandom_range(0, 99) >= 11);
      end
    end
  end

  // watchdog on beats moving on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_span <= 0;
    end else begin
      idle_span <= idle_span + 1;
    end
    if (idle_span >= WatchdogLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    logic [255:0] hash_a;
    logic [255:0] hash_b;
    logic [31:0]  height;
    int           roll;
    int           filled;
    sb = new();
    hash_a = rand_hash();
    hash_b = rand_hash();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table: no zone, hash passes, height zero never allows an alternative
    drive_beat(OpQuery, 32'h0, 32'h0, '0);
    drive_beat(OpQuery, 32'hFFFF_FFFF, 32'hFFFF_FFFF, {256{1'b1}});
    drive_beat(OpQuery, 32'd77, 32'd5, hash_a);
    // single checkpoint, alternative decision on either side of it
    drive_beat(OpInsert, 32'd1000, 32'hFFFF_FFFF, hash_a);
    drive_beat(OpQuery, 32'd1000, 32'd999, hash_a);
    drive_beat(OpQuery, 32'd1000, 32'd1000, hash_b);
    drive_beat(OpQuery, 32'd1001, 32'd1000, hash_a);
    drive_beat(OpQuery, 32'd999, 32'd5000, hash_a);
    drive_beat(OpQuery, 32'd1001, 32'hFFFF_FFFF, '0);
    // checkpoint at height zero, all-zero hash, then a duplicate of it
    drive_beat(OpInsert, 32'h0, 32'h0, '0);
    drive_beat(OpInsert, 32'h0, 32'h0, {256{1'b1}});
    drive_beat(OpQuery, 32'h0, 32'h0, '0);
    drive_beat(OpQuery, 32'h0, 32'h0, 256'd1 << 255);
    drive_beat(OpQuery, 32'd500, 32'd999, hash_b);
    drive_beat(OpQuery, 32'hFFFF_FFFF, 32'hFFFF_FFFE, {256{1'b1}});

    // random part: inserts are frequent until the table fills, after that they
    // hit the full and duplicate refusals
    for (int n = 0; n < RandomBeats; n++) begin
      calm = (n >= 900 && n < 1150);
      if (n == 400) hold_request = 1'b1;
      roll = $urandom_range(0, 99);
      filled = sb.cp_height.size();
      if ((filled < TableEntriesDefault && roll < 25) || roll < 12) begin
        if (filled > 0 && $urandom_range(0, 3) == 0) begin
          height = sb.cp_height[$urandom_range(0, filled - 1)];
        end else begin
          height = pick_height();
        end
        drive_beat(OpInsert, height, $urandom, rand_hash());
      end else begin
        drive_query();
      end
    end
    s_axis_tvalid <= 1'b0;

    // drain, then give a late or extra beat time to show up
    while (sb.pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/hct_pkg.sv
rtl/core/hct_ctrl.sv
rtl/core/hct_datapath.sv
rtl/core/height_checkpoint_table.sv
verif/hct_scoreboard_pkg.sv
verif/tb_top.sv
